@@ sv/dwalu_pkg.sv @@
// Shared types and constants for the double-width unsigned ALU.
// No dependencies; compiled before the channel interfaces and the modules.
package dwalu_pkg;

   // Fixed width of every word field on the channels
   localparam int FIELD_BITS = 32;
   localparam int OP_BITS    = 4;
   localparam int SHAMT_BITS = 7;

   typedef logic [OP_BITS-1:0] opcode_type;

   // Operation codes
   localparam opcode_type OP_ADD = 4'd0;
   localparam opcode_type OP_SUB = 4'd1;
   localparam opcode_type OP_MUL = 4'd2;
   localparam opcode_type OP_DIV = 4'd3;
   localparam opcode_type OP_MOD = 4'd4;
   localparam opcode_type OP_AND = 4'd5;
   localparam opcode_type OP_OR  = 4'd6;
   localparam opcode_type OP_XOR = 4'd7;
   localparam opcode_type OP_NOT = 4'd8;
   localparam opcode_type OP_SHL = 4'd9;
   localparam opcode_type OP_SHR = 4'd10;
   localparam opcode_type OP_INC = 4'd11;
   localparam opcode_type OP_DEC = 4'd12;

   typedef logic [FIELD_BITS-1:0] word_type;
   typedef logic [SHAMT_BITS-1:0] shamt_type;

endpackage

@@ sv/dwalu_if.sv @@
// Valid/ready channel interfaces for the request and response sides.
// Depends on dwalu_pkg for the field types.
interface dwalu_req_if
   import dwalu_pkg::*;
   ();
   logic       valid;
   logic       ready;
   opcode_type opcode;
   word_type   a_high;
   word_type   a_low;
   word_type   b_high;
   word_type   b_low;
   shamt_type  shift_amount;

   modport source (output valid, opcode, a_high, a_low, b_high, b_low, shift_amount,
                   input ready);
   modport sink   (input valid, opcode, a_high, a_low, b_high, b_low, shift_amount,
                   output ready);
endinterface

interface dwalu_rsp_if
   import dwalu_pkg::*;
   ();
   logic     valid;
   logic     ready;
   word_type result_high;
   word_type result_low;
   logic     a_equals_b;
   logic     a_below_b;
   logic     a_above_b;
   logic     a_is_zero;
   logic     divide_by_zero;

   modport source (output valid, result_high, result_low, a_equals_b, a_below_b,
                   a_above_b, a_is_zero, divide_by_zero, input ready);
   modport sink   (input valid, result_high, result_low, a_equals_b, a_below_b,
                   a_above_b, a_is_zero, divide_by_zero, output ready);
endinterface

@@ sv/dwalu_addsub.sv @@
// Shared double-width adder/subtractor with one guard bit and carry out.
// Depends on nothing; instantiated by the ALU top level.
module dwalu_addsub #(
   parameter int DW = 64
) (
   input  logic [DW:0]   x,
   input  logic [DW:0]   y,
   input  logic          sub,
   output logic [DW+1:0] sum
);
   logic [DW:0] y_op;

   // Subtract as x + ~y + 1; sum[DW+1] is then set when x >= y
   assign y_op = sub ? ~y : y;
   assign sum  = {1'b0, x} + {1'b0, y_op} + (DW+2)'(sub);

endmodule

@@ sv/double_width_unsigned_alu.sv @@
// Double-width unsigned ALU.
//
// Request channel (req_chan): opcode, operand A as a_high/a_low, operand B as
// b_high/b_low and a shift amount. A transfer takes place when valid and ready
// are both high; ready is high only while no operation is in progress.
// Response channel (rsp_chan): result_high/result_low and the compare flags of
// A against B, plus divide_by_zero for div/mod with B of zero. One response
// per request, in order.
//
// Add, sub, inc, dec, logic ops, zero or long shifts and zero-divisor cases
// need no iteration steps. Multiply and divide/modulo take one shared adder
// step per operand bit. Shifts move one bit per cycle.
// A new request is taken the cycle after the result is registered.
// The result sits in an output register; a stalled receiver holds it there
// and the next request may be transferred and worked on meanwhile, its
// result waiting until the register is free.
// Synchronous reset returns the sequencer to idle and drops rsp_chan.valid.
module double_width_unsigned_alu
   import dwalu_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   dwalu_req_if.sink     req_chan,
   dwalu_rsp_if.source   rsp_chan
);
   localparam int DW    = 2 * WORD_BITS;
   localparam int CNT_W = $clog2(DW + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   opcode_type       op_ff, op_in;
   logic [DW-1:0]    a_ff, a_in;
   logic [DW-1:0]    b_ff, b_in;
   logic [DW-1:0]    acc_ff, acc_in;
   logic             dz_ff, dz_in;
   logic             eq_ff, eq_in, lt_ff, lt_in, gt_ff, gt_in, az_ff, az_in;

   logic             rsp_valid_ff, rsp_valid_in;
   word_type         rsp_hi_ff, rsp_lo_ff;
   logic             rsp_eq_ff, rsp_lt_ff, rsp_gt_ff, rsp_az_ff, rsp_dz_ff;

   logic             accept, stepping, finish;
   logic [DW-1:0]    req_a, req_b;
   logic [DW:0]      unit_x, unit_y;
   logic             unit_sub;
   logic [DW+1:0]    unit_sum;
   logic [DW-1:0]    div_rsh;
   logic             div_take;
   logic [DW-1:0]    result;

   // Operand words taken to the internal word width
   assign req_a = {WORD_BITS'(req_chan.a_high), WORD_BITS'(req_chan.a_low)};
   assign req_b = {WORD_BITS'(req_chan.b_high), WORD_BITS'(req_chan.b_low)};

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign stepping       = (state_ff == ST_RUN) && (count_ff != '0);
   assign finish         = (state_ff == ST_RUN) && (count_ff == '0)
                           && (!rsp_valid_ff || rsp_chan.ready);

   // Division step: bring the next dividend bit into the partial remainder
   assign div_rsh  = {acc_ff[DW-2:0], a_ff[DW-1]};
   assign div_take = unit_sum[DW+1];

   // Operand selection for the shared adder
   always_comb begin
      unit_x   = {1'b0, a_ff};
      unit_y   = {1'b0, b_ff};
      unit_sub = 1'b0;
      unique case (op_ff)
         OP_MUL: begin
            unit_x = {1'b0, acc_ff};
            unit_y = {1'b0, a_ff};
         end
         OP_DIV, OP_MOD: begin
            unit_x   = {acc_ff[DW-1], div_rsh};
            unit_sub = 1'b1;
         end
         OP_SUB: unit_sub = 1'b1;
         OP_INC: unit_y = (DW+1)'(1);
         OP_DEC: begin
            unit_y   = (DW+1)'(1);
            unit_sub = 1'b1;
         end
         default: ;
      endcase
   end

   dwalu_addsub #(.DW(DW)) u_addsub (
      .x   (unit_x),
      .y   (unit_y),
      .sub (unit_sub),
      .sum (unit_sum)
   );

   // Final result selection
   always_comb begin
      result = '0;
      if (!dz_ff) begin
         unique case (op_ff)
            OP_ADD, OP_SUB, OP_INC, OP_DEC: result = unit_sum[DW-1:0];
            OP_MUL, OP_MOD:                 result = acc_ff;
            OP_DIV, OP_SHL, OP_SHR:         result = a_ff;
            OP_AND:                         result = a_ff & b_ff;
            OP_OR:                          result = a_ff | b_ff;
            OP_XOR:                         result = a_ff ^ b_ff;
            OP_NOT:                         result = ~a_ff;
            default:                        result = '0;
         endcase
      end
   end

   // Sequencer and working registers
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      op_in    = op_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      dz_in    = dz_ff;
      eq_in    = eq_ff;
      lt_in    = lt_ff;
      gt_in    = gt_ff;
      az_in    = az_ff;
      if (accept) begin
         state_in = ST_RUN;
         op_in    = req_chan.opcode;
         a_in     = req_a;
         b_in     = req_b;
         acc_in   = '0;
         count_in = '0;
         dz_in    = 1'b0;
         eq_in    = (req_a == req_b);
         lt_in    = (req_a < req_b);
         gt_in    = (req_a > req_b);
         az_in    = (req_a == '0);
         unique case (req_chan.opcode)
            OP_MUL: count_in = CNT_W'(DW);
            OP_DIV, OP_MOD: begin
               if (req_b == '0) begin
                  dz_in = 1'b1;
               end else begin
                  count_in = CNT_W'(DW);
               end
            end
            OP_SHL, OP_SHR: begin
               if (int'(req_chan.shift_amount) >= DW) begin
                  a_in = '0;
               end else begin
                  count_in = CNT_W'(req_chan.shift_amount);
               end
            end
            default: ;
         endcase
      end else if (stepping) begin
         count_in = count_ff - CNT_W'(1);
         unique case (op_ff)
            OP_MUL: begin
               if (b_ff[0]) begin
                  acc_in = unit_sum[DW-1:0];
               end
               a_in = {a_ff[DW-2:0], 1'b0};
               b_in = {1'b0, b_ff[DW-1:1]};
            end
            OP_DIV, OP_MOD: begin
               acc_in = div_take ? unit_sum[DW-1:0] : div_rsh;
               a_in   = {a_ff[DW-2:0], div_take};
            end
            OP_SHL: a_in = {a_ff[DW-2:0], 1'b0};
            OP_SHR: a_in = {1'b0, a_ff[DW-1:1]};
            default: ;
         endcase
      end else if (finish) begin
         state_in = ST_IDLE;
      end
   end

   // Response valid: set on a new result, cleared on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      dz_ff  <= dz_in;
      eq_ff  <= eq_in;
      lt_ff  <= lt_in;
      gt_ff  <= gt_in;
      az_ff  <= az_in;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_hi_ff <= FIELD_BITS'(result[DW-1:WORD_BITS]);
         rsp_lo_ff <= FIELD_BITS'(result[WORD_BITS-1:0]);
         rsp_eq_ff <= eq_ff;
         rsp_lt_ff <= lt_ff;
         rsp_gt_ff <= gt_ff;
         rsp_az_ff <= az_ff;
         rsp_dz_ff <= dz_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.result_high    = rsp_hi_ff;
   assign rsp_chan.result_low     = rsp_lo_ff;
   assign rsp_chan.a_equals_b     = rsp_eq_ff;
   assign rsp_chan.a_below_b      = rsp_lt_ff;
   assign rsp_chan.a_above_b      = rsp_gt_ff;
   assign rsp_chan.a_is_zero      = rsp_az_ff;
   assign rsp_chan.divide_by_zero = rsp_dz_ff;

   // Checks
   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot({rsp_eq_ff, rsp_lt_ff, rsp_gt_ff}))
      else $error("compare flags not exactly one of eq/below/above");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_dz_ff |-> (rsp_hi_ff == '0) && (rsp_lo_ff == '0))
      else $error("zero divisor response carries a non-zero result");

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN) && !req_chan.ready)
      else $error("sequencer not busy after request transfer");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      stepping |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("iteration counter did not step by one");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !finish)
      else $error("stalled response overwritten");

endmodule

@@ tb/tb_double_width_unsigned_alu.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for double_width_unsigned_alu: a queued request driver,
// a stalling response monitor and a behavioural predictor of every operation.
// Depends on dwalu_pkg, dwalu_req_if/dwalu_rsp_if and the ALU itself.
module tb_double_width_unsigned_alu;
   import dwalu_pkg::*;

   localparam int DWORD_BITS  = 2 * FIELD_BITS;
   localparam int RAND_ITEMS  = 1300;
   localparam int DRAIN_CYCLES = 100;
   localparam word_type WORD_MAX = '1;

   typedef struct {
      opcode_type opcode;
      word_type   a_high;
      word_type   a_low;
      word_type   b_high;
      word_type   b_low;
      shamt_type  shift_amount;
   } alu_req_type;

   typedef struct {
      word_type result_high;
      word_type result_low;
      logic     a_equals_b;
      logic     a_below_b;
      logic     a_above_b;
      logic     a_is_zero;
      logic     divide_by_zero;
   } alu_rsp_type;

   logic clock = 1'b0;
   logic reset;

   dwalu_req_if req_if ();
   dwalu_rsp_if rsp_if ();

   double_width_unsigned_alu dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   alu_req_type requests_to_send[$];
   alu_rsp_type alu_results_due[$];
   alu_req_type in_flight;
   alu_rsp_type want;
   bit       stim_loaded = 1'b0;
   int       fail_count  = 0;
   int       burst_left  = 0;
   int       gap_left    = 0;
   logic [15:0] ready_pattern;
   int       pattern_age;

   // Clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Expected response for one request
   function automatic alu_rsp_type predict_alu_result(alu_req_type r);
      logic [DWORD_BITS-1:0] a, b, y;
      alu_rsp_type o;
      a = {r.a_high, r.a_low};
      b = {r.b_high, r.b_low};
      y = '0;
      o.divide_by_zero = 1'b0;
      case (r.opcode)
         OP_ADD: y = a + b;
         OP_SUB: y = a - b;
         OP_MUL: y = a * b;
         OP_DIV: begin
            if (b == '0) o.divide_by_zero = 1'b1;
            else y = a / b;
         end
         OP_MOD: begin
            if (b == '0) o.divide_by_zero = 1'b1;
            else y = a % b;
         end
         OP_AND: y = a & b;
         OP_OR:  y = a | b;
         OP_XOR: y = a ^ b;
         OP_NOT: y = ~a;
         OP_SHL: y = (r.shift_amount >= DWORD_BITS) ? '0 : a << r.shift_amount;
         OP_SHR: y = (r.shift_amount >= DWORD_BITS) ? '0 : a >> r.shift_amount;
         OP_INC: y = a + 1'b1;
         OP_DEC: y = a - 1'b1;
         default: y = '0;   // unused opcodes give zero
      endcase
      o.result_high = y[DWORD_BITS-1:FIELD_BITS];
      o.result_low  = y[FIELD_BITS-1:0];
      o.a_equals_b  = (a == b);
      o.a_below_b   = (a < b);
      o.a_above_b   = (a > b);
      o.a_is_zero   = (a == '0);
      return o;
   endfunction

   task automatic queue_request(opcode_type op, word_type ah, word_type al,
                                word_type bh, word_type bl, shamt_type sh);
      alu_req_type r;
      r.opcode       = op;
      r.a_high       = ah;
      r.a_low        = al;
      r.b_high       = bh;
      r.b_low        = bl;
      r.shift_amount = sh;
      requests_to_send.push_back(r);
   endtask

   // Operand words biased towards edges
   function automatic word_type rand_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return WORD_MAX;
         2: return word_type'($urandom_range(0, 15));
         3: return ~word_type'($urandom_range(0, 15));
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic int next_gap();
      case ($urandom_range(0, 5))
         0, 1: return 0;
         2: return $urandom_range(11, 70);
         default: return $urandom_range(1, 10);
      endcase
   endfunction

   task automatic check_field(string name, logic [FIELD_BITS-1:0] exp_val,
                              logic [FIELD_BITS-1:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %h, actual %h", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   // Reset and initial drive
   initial begin
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.opcode        = OP_ADD;
      req_if.a_high        = '0;
      req_if.a_low         = '0;
      req_if.b_high        = '0;
      req_if.b_low         = '0;
      req_if.shift_amount  = '0;
      rsp_if.ready         = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Stimulus: directed corners, then random traffic
   initial begin
      alu_req_type r;
      // wrap-around, extremes and equal operands
      queue_request(OP_ADD, WORD_MAX, WORD_MAX, '0, 32'd1, '0);
      queue_request(OP_ADD, 32'h1234_5678, 32'h9abc_def0, 32'h1234_5678, 32'h9abc_def0, '0);
      queue_request(OP_SUB, '0, '0, '0, 32'd1, '0);
      queue_request(OP_MUL, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, '0);
      queue_request(OP_DIV, WORD_MAX, WORD_MAX, '0, 32'd1, '0);
      queue_request(OP_DIV, WORD_MAX, 32'd7, '0, '0, '0);          // zero divisor
      queue_request(OP_MOD, 32'd5, 32'd5, '0, '0, '0);             // zero divisor
      queue_request(OP_MOD, '0, 32'd3, WORD_MAX, WORD_MAX, '0);    // A below B
      queue_request(OP_AND, WORD_MAX, '0, 32'haaaa_aaaa, 32'h5555_5555, '0);
      queue_request(OP_OR,  32'h5555_5555, '0, 32'haaaa_aaaa, '0, '0);
      queue_request(OP_XOR, WORD_MAX, WORD_MAX, 32'h0f0f_0f0f, 32'hf0f0_f0f0, '0);
      queue_request(OP_NOT, '0, '0, WORD_MAX, WORD_MAX, '0);
      queue_request(OP_SHL, 32'hdead_beef, 32'h0123_4567, '0, '0, '0);  // zero shift
      queue_request(OP_SHL, '0, 32'd1, '0, '0, shamt_type'(DWORD_BITS - 1));
      queue_request(OP_SHL, WORD_MAX, WORD_MAX, '0, '0, shamt_type'(DWORD_BITS));
      queue_request(OP_SHL, WORD_MAX, WORD_MAX, '0, '0, '1);
      queue_request(OP_SHR, 32'h8000_0000, '0, '0, '0, 7'd1);
      queue_request(OP_SHR, WORD_MAX, WORD_MAX, '0, '0, shamt_type'(DWORD_BITS));
      queue_request(OP_INC, WORD_MAX, WORD_MAX, '0, '0, '0);
      queue_request(OP_DEC, '0, '0, '0, '0, '0);
      // unused opcodes still report the compare flags
      for (int op = OP_DEC + 1; op < 2 ** OP_BITS; op++)
         queue_request(opcode_type'(op), WORD_MAX, 32'd9, 32'd1, WORD_MAX, '1);

      for (int n = 0; n < RAND_ITEMS; n++) begin
         if ($urandom_range(0, 9) == 0)
            r.opcode = opcode_type'($urandom_range(0, 2 ** OP_BITS - 1));
         else
            r.opcode = opcode_type'($urandom_range(OP_ADD, OP_DEC));
         r.a_high = rand_word();
         r.a_low  = rand_word();
         if ($urandom_range(0, 7) == 0) begin
            r.b_high = r.a_high;
            r.b_low  = r.a_low;
         end else begin
            r.b_high = rand_word();
            r.b_low  = rand_word();
         end
         if ($urandom_range(0, 1) == 0)
            r.shift_amount = shamt_type'($urandom_range(0, DWORD_BITS));
         else
            r.shift_amount = shamt_type'($urandom);
         requests_to_send.push_back(r);
      end
      stim_loaded = 1'b1;
   end

   // Request driver: bursts of transfers separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            alu_results_due.push_back(predict_alu_result(in_flight));
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0 || requests_to_send.size() == 0) begin
               req_if.valid <= 1'b0;
               if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
               in_flight = requests_to_send.pop_front();
               req_if.opcode       <= in_flight.opcode;
               req_if.a_high       <= in_flight.a_high;
               req_if.a_low        <= in_flight.a_low;
               req_if.b_high       <= in_flight.b_high;
               req_if.b_low        <= in_flight.b_low;
               req_if.shift_amount <= in_flight.shift_amount;
               req_if.valid        <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left   <= next_gap();
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // Response ready: rotating pattern, reshuffled when pattern_age wraps
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready  <= 1'b0;
         ready_pattern <= '1;
         pattern_age   <= 0;
      end else begin
         rsp_if.ready <= ready_pattern[0];
         pattern_age  <= (pattern_age + 1) % 64;
         if (pattern_age == 63) begin
            case ($urandom_range(0, 3))
               0: ready_pattern <= '1;
               1: ready_pattern <= 16'($urandom & $urandom) | 16'd1;
               default: ready_pattern <= 16'($urandom) | 16'd1;
            endcase
         end else begin
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
         end
      end
   end

   // Response monitor: in-order compare against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (alu_results_due.size() == 0) begin
            $error("response transfer with no request outstanding");
            fail_count++;
         end else begin
            want = alu_results_due.pop_front();
            check_field("result_high", want.result_high, rsp_if.result_high);
            check_field("result_low", want.result_low, rsp_if.result_low);
            check_field("a_equals_b", want.a_equals_b, rsp_if.a_equals_b);
            check_field("a_below_b", want.a_below_b, rsp_if.a_below_b);
            check_field("a_above_b", want.a_above_b, rsp_if.a_above_b);
            check_field("a_is_zero", want.a_is_zero, rsp_if.a_is_zero);
            check_field("divide_by_zero", want.divide_by_zero, rsp_if.divide_by_zero);
         end
      end
   end

   // End of run: drain, then settle for a worst-case operation time
   initial begin
      wait (stim_loaded && requests_to_send.size() == 0 && !reset);
      @(posedge clock);
      wait (!req_if.valid);
      wait (alu_results_due.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && alu_results_due.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Watchdog
   initial begin
      #8_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
